/* src/mma_pkg.sv */
// Constants shared by the multichannel moving average block.
// Field widths, window geometry and derived memory and divider sizes.
// No dependencies.
package mma_pkg;

    // Window geometry
    localparam int CHANNELS = 4;
    localparam int WINDOW   = 16;

    // Field widths
    localparam int CH_W     = 2;
    localparam int SAMPLE_W = 12;
    localparam int TDATA_W  = ((CH_W + SAMPLE_W + 7) / 8) * 8;

    // Derived state widths
    localparam int SUM_W  = $clog2(WINDOW * ((1 << SAMPLE_W) - 1) + 1);
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    // Sample ring memory
    localparam int RING_DEPTH = CHANNELS * WINDOW;
    localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    // Serial divider step counter
    localparam int DIV_CW = $clog2(SUM_W + 1);

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

endpackage

/* src/multichannel_moving_average.sv */
// Multichannel moving average: per-channel ring memory, running sums and a
// serial restoring divider for the warm-up aware average.
// Depends on mma_pkg.
//
//  channel | direction | tdata (low bit up)                 | handshake
//  --------+-----------+------------------------------------+------------------
//  s_      | in        | channel[1:0], sample[13:2]         | s_tvalid/s_tready
//  m_      | out       | out_channel[1:0], average[13:2]    | m_tvalid/m_tready
//
// Each word passes a ring memory read, an update of sum and ring, SUM_W
// divider steps and a load of the output register, and the next word is
// taken only after that. The one-bit-per-cycle divider sets the pace.
// Reset clears sums, fill counts and write positions; the ring needs no clear.
// A finished word waits in the output register while the next word is taken.
module multichannel_moving_average (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [mma_pkg::TDATA_W-1:0] s_tdata,   // channel[1:0], sample[13:2]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [mma_pkg::TDATA_W-1:0] m_tdata    // out_channel[1:0], average[13:2]
);
    import mma_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPD,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t                state_reg;
    state_t                state_next;

    // Per-channel control state
    logic [SUM_W-1:0]      sum_reg  [CHANNELS];
    logic [FILL_W-1:0]     fill_reg [CHANNELS];
    logic [POS_W-1:0]      pos_reg  [CHANNELS];

    // Sample ring memory
    logic [SAMPLE_W-1:0]   ring_mem [RING_DEPTH];
    logic [SAMPLE_W-1:0]   ring_q_reg;
    logic [RING_AW-1:0]    ring_ra;
    logic                  ring_re;
    logic                  ring_we;

    // Current word
    logic [CH_W-1:0]       ch_reg;
    logic [SAMPLE_W-1:0]   sample_reg;
    logic                  ch_ok_reg;
    logic [RING_AW-1:0]    addr_reg;

    // Divider
    logic [SUM_W-1:0]      quo_reg;
    logic [SUM_W-1:0]      quo_next;
    logic [FILL_W-1:0]     rem_reg;
    logic [FILL_W-1:0]     rem_next;
    logic [FILL_W-1:0]     div_reg;
    logic [FILL_W-1:0]     div_next;
    logic [DIV_CW-1:0]     cnt_reg;
    logic [DIV_CW-1:0]     cnt_next;

    // Output register
    logic                  m_valid_reg;
    logic                  m_valid_next;
    logic [CH_W-1:0]       m_ch_reg;
    logic [SAMPLE_W-1:0]   m_avg_reg;
    logic [SAMPLE_W-1:0]   m_avg_next;

    logic                  s_acc;
    logic [CH_W-1:0]       s_ch;
    logic [SAMPLE_W-1:0]   s_sample;
    logic                  s_ch_ok;
    logic [CH_W-1:0]       ch_idx;
    logic                  full;
    logic [SUM_W-1:0]      sum_next;
    logic [FILL_W-1:0]     fill_next;
    logic [POS_W-1:0]      pos_next;
    logic [FILL_W:0]       rem_sh;
    logic                  ge;
    logic                  out_free;

    assign s_ch     = s_tdata[CH_W-1:0];
    assign s_sample = s_tdata[CH_W+SAMPLE_W-1:CH_W];
    assign s_ch_ok  = ({1'b0, s_ch} < (CH_W + 1)'(CHANNELS));
    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // Ring read address from the incoming word
    always_comb begin
        ring_ra = '0;
        if (s_ch_ok) begin
            ring_ra = RING_AW'(s_ch) * RING_AW'(WINDOW) + RING_AW'(pos_reg[s_ch]);
        end
    end
    assign ring_re = s_acc;
    assign ring_we = (state_reg == ST_UPD) && ch_ok_reg;

    // Sum, fill and position update for the held channel
    always_comb begin
        ch_idx    = ch_ok_reg ? ch_reg : '0;
        full      = (fill_reg[ch_idx] >= FILL_W'(WINDOW));
        sum_next  = sum_reg[ch_idx] - (full ? SUM_W'(ring_q_reg) : '0)
                    + SUM_W'(sample_reg);
        fill_next = full ? fill_reg[ch_idx] : fill_reg[ch_idx] + 1'b1;
        pos_next  = (pos_reg[ch_idx] == POS_W'(WINDOW - 1)) ? '0
                    : pos_reg[ch_idx] + 1'b1;
    end

    // Restoring divider step: one quotient bit per cycle
    always_comb begin
        rem_sh = {rem_reg, quo_reg[SUM_W-1]};
        ge     = (rem_sh >= {1'b0, div_reg});
    end

    // Next-state logic
    always_comb begin
        state_next   = state_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        div_next     = div_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_avg_next   = (quo_reg > SUM_W'(SAMPLE_MAX)) ? SAMPLE_MAX : quo_reg[SAMPLE_W-1:0];
        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                rem_next = '0;
                cnt_next = '0;
                if (ch_ok_reg) begin
                    quo_next   = sum_next;
                    div_next   = fill_next;
                    state_next = ST_DIV;
                end else begin
                    quo_next   = '0;
                    div_next   = FILL_W'(1);
                    state_next = ST_OUT;
                end
            end
            ST_DIV: begin
                quo_next = {quo_reg[SUM_W-2:0], ge};
                rem_next = ge ? FILL_W'(rem_sh - {1'b0, div_reg}) : rem_sh[FILL_W-1:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CW'(SUM_W - 1)) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Ring memory: write back the new sample, read the oldest one
    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[addr_reg] <= sample_reg;
        end
        if (ring_re) begin
            ring_q_reg <= ring_mem[ring_ra];
        end
    end

    // State, per-channel control state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                sum_reg[i]  <= '0;
                fill_reg[i] <= '0;
                pos_reg[i]  <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (ring_we) begin
                sum_reg[ch_idx]  <= sum_next;
                fill_reg[ch_idx] <= fill_next;
                pos_reg[ch_idx]  <= pos_next;
            end
        end
        // Payload registers
        if (s_acc) begin
            ch_reg     <= s_ch;
            sample_reg <= s_sample;
            ch_ok_reg  <= s_ch_ok;
            addr_reg   <= ring_ra;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        cnt_reg <= cnt_next;
        if (state_reg == ST_OUT && out_free) begin
            m_ch_reg  <= ch_reg;
            m_avg_reg <= m_avg_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TDATA_W'({m_avg_reg, m_ch_reg});

    // Only one word is in flight
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> !s_tready)
        else $error("word accepted while another is in flight");

    // Fill count stays within the window
    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPD) |-> (fill_reg[ch_idx] <= FILL_W'(WINDOW)))
        else $error("fill count beyond window");

    // Divider remainder stays below the divisor
    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT) |-> (rem_reg < div_reg))
        else $error("divider remainder not below divisor");

endmodule

/* verif/testbench.sv */
// Self-checking testbench for multichannel_moving_average: drives sample words on the
// input stream and checks each average word against a per-channel window predictor.
// Depends on mma_pkg and the multichannel_moving_average top level.
module testbench;
    import mma_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_WORDS = 450;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [CH_W-1:0]     channel;
        logic [SAMPLE_W-1:0] average;
    } avg_word_t;

    // Per-channel window state and the queue of averages still to come
    class moving_avg_predictor;
        bit [SAMPLE_W-1:0] ring [CHANNELS][WINDOW];
        bit [SUM_W-1:0]    sums [CHANNELS];
        bit [FILL_W-1:0]   fills [CHANNELS];
        bit [POS_W-1:0]    wpos [CHANNELS];
        avg_word_t         expected_avgs [$];
        int                mismatches = 0;

        // Fold one accepted sample into its channel and queue the new average
        function void take_sample(logic [CH_W-1:0] ch, logic [SAMPLE_W-1:0] smp);
            avg_word_t      word;
            bit [SUM_W-1:0] quot;
            int             p;
            word.channel = ch;
            word.average = '0;
            // A channel beyond the configured count leaves the state alone
            if (int'(ch) < CHANNELS) begin
                p = int'(wpos[ch]);
                if (int'(fills[ch]) >= WINDOW) begin
                    sums[ch] -= ring[ch][p];
                end else begin
                    fills[ch] += 1'b1;
                end
                ring[ch][p] = smp;
                sums[ch] += smp;
                wpos[ch] = (p == WINDOW - 1) ? '0 : POS_W'(p + 1);
                quot = sums[ch] / fills[ch];
                word.average = (quot > SAMPLE_MAX) ? SAMPLE_MAX : quot[SAMPLE_W-1:0];
            end
            expected_avgs.push_back(word);
        endfunction

        // Compare one delivered word with the oldest queued average
        function void check_average(logic [CH_W-1:0] ch, logic [SAMPLE_W-1:0] avg);
            avg_word_t want;
            if (expected_avgs.size() == 0) begin
                $error("unexpected word: out_channel %0d average %0d", ch, avg);
                mismatches++;
                return;
            end
            want = expected_avgs.pop_front();
            if (ch !== want.channel) begin
                $error("out_channel: expected %0d, actual %0d", want.channel, ch);
                mismatches++;
            end
            if (avg !== want.average) begin
                $error("average: expected %0d, actual %0d", want.average, avg);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_avgs.size();
        endfunction
    endclass

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata  = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;

    moving_avg_predictor board = new;
    bit                  hold_request = 1'b0;
    int                  cycle_count  = 0;

    multichannel_moving_average u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever begin
            #CLK_HALF aclk = ~aclk;
        end
    end

    // Offer one sample word and hold it until the block takes it
    task automatic send_sample(input logic [CH_W-1:0] ch, input logic [SAMPLE_W-1:0] smp);
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'({smp, ch});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.take_sample(ch, smp);
    endtask

    // Drop valid for a number of cycles; zero keeps the stream back to back
    task automatic idle_sender(input int cycles);
        if (cycles > 0) begin
            s_tvalid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    // Mostly short gaps, now and then a long one
    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return SAMPLE_MAX;
        return SAMPLE_W'($urandom_range(0, (1 << SAMPLE_W) - 1));
    endfunction

    // Receiver: check words, stall at random, honor a long hold-off on request
    initial begin
        int hold_left;
        int run_left;
        int r;
        bit hold_taken;
        hold_left  = 0;
        run_left   = 0;
        hold_taken = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                board.check_average(m_tdata[CH_W-1:0], m_tdata[CH_W +: SAMPLE_W]);
            end
            if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (run_left > 0) begin
                run_left--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    m_tready <= 1'b1;
                    run_left = $urandom_range(0, 40);
                end else if (r < 90) begin
                    m_tready <= 1'b0;
                    run_left = $urandom_range(0, 2);
                end else begin
                    m_tready <= 1'b0;
                    run_left = $urandom_range(10, 60);
                end
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Stimulus
    initial begin
        int i;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes, warm-up averaging, a full window and its wrap
        send_sample(2'd0, '0);
        send_sample(2'd1, SAMPLE_MAX);
        send_sample(2'd2, 12'hAAA);
        send_sample(2'd2, 12'h555);
        send_sample(2'd1, '0);
        idle_sender(sender_gap());
        for (i = 0; i < WINDOW + 1; i++) begin
            send_sample(2'd3, SAMPLE_MAX);
        end
        // Oldest full-scale sample drops out of the window here
        send_sample(2'd3, '0);
        idle_sender(sender_gap());

        // Random part: no-gap stretch opens every hundred words, longest at word 100
        for (i = 0; i < RANDOM_WORDS; i++) begin
            if (i == 100) hold_request = 1'b1;
            if (i == 250) begin
                // Let the block drain completely before going on
                idle_sender(1);
                while (board.pending() != 0) @(posedge aclk);
            end
            send_sample(CH_W'($urandom_range(0, CHANNELS - 1)), pick_sample());
            if ((i % 100) >= 30 && !(i >= 100 && i < 140)) begin
                idle_sender(sender_gap());
            end
        end

        // Drain and settle
        idle_sender(1);
        while (board.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
